// ===== rtl/pohtrk_pkg.sv =====
// Shared types and constants for the PIR occupancy hold tracker.
// Used by pohtrk_cfg, pohtrk_core and pir_occupancy_hold_tracker.
`default_nettype none

package pohtrk_pkg;

    // Register field widths
    localparam int HOLD_W   = 26;
    localparam int IVL_W    = 27;
    localparam int RUN_W    = 4;
    localparam int CFG_W    = 27;
    localparam int CFG_IDX_W = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPORT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESCAN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RUN_LEN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PRECONF  = 3'd4;

    // Register reset values
    localparam logic [HOLD_W-1:0] HOLD_RESET    = 26'd60000;
    localparam logic [IVL_W-1:0]  REPORT_RESET  = 27'd1000;
    localparam logic [IVL_W-1:0]  RESCAN_RESET  = 27'd30000;
    localparam logic [RUN_W-1:0]  RUN_LEN_RESET = 4'd3;
    localparam logic              PRECONF_RESET = 1'b0;

    // Saturation point of the high-level run counter
    localparam logic [RUN_W-1:0] RUN_MAX = 4'd15;

    typedef struct packed {
        logic [HOLD_W-1:0] hold_ms;
        logic [IVL_W-1:0]  report_ivl;
        logic [IVL_W-1:0]  rescan_ivl;
        logic [RUN_W-1:0]  run_len;
        logic              preconf;
    } cfg_t;

    // Write strobe for the preconfirm register, seen by the tracker state
    typedef struct packed {
        logic load;
        logic value;
    } preconf_wr_t;

    typedef struct packed {
        logic occupied;
        logic occupancy_changed;
        logic motion_now;
        logic sensor_confirmed;
        logic confirm_event;
        logic report_due;
        logic rescan_due;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/pir_occupancy_hold_tracker.sv =====
// Top level of the PIR occupancy hold tracker: input and result registers
// around the tracker core. Depends on pohtrk_pkg, pohtrk_cfg, pohtrk_core.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one poll per item:
//   now_ms, a free-running millisecond stamp, and pir_level.
//   Output channel (out_valid / out_stall) returns exactly one result per
//   poll: occupancy, its change flag, motion, confirmation and the report
//   and rescan due flags.
//   An accepted poll waits in the input register; its result is then
//   registered and shown on out_valid. Throughput: one poll per cycle while
//   out_stall is low, set by the single input register feeding the tracker state update.
//   Configuration: cfg_wr_en / cfg_index / cfg_data write one register per
//   cycle, no read-back; write only while no poll is in flight. Writing the
//   preconfirm register before the first poll also sets the confirmed state.
//   Reset: rst_n clears both stages and loads register defaults (hold 60 s,
//   report 1 s, rescan 30 s, run length 3, not preconfirmed).
//   Stall: while out_stall holds a result, one more poll is taken into the
//   input register; after that in_stall rises until the result is taken.
`default_nettype none

module pir_occupancy_hold_tracker #(
    parameter int TIME_WIDTH = 32
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_wr_en,
    input  wire logic [pohtrk_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [pohtrk_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                             in_valid,
    output      logic                             in_stall,
    input  wire logic [31:0]                      now_ms,
    input  wire logic                             pir_level,
    output      logic                             out_valid,
    input  wire logic                             out_stall,
    output      logic                             occupied,
    output      logic                             occupancy_changed,
    output      logic                             motion_now,
    output      logic                             sensor_confirmed,
    output      logic                             confirm_event,
    output      logic                             report_due,
    output      logic                             rescan_due
);
    import pohtrk_pkg::*;

    cfg_t        cfg;
    preconf_wr_t preconf_wr;
    result_t     result;
    result_t     res_reg;

    logic                  in_vld_reg, in_vld_next;
    logic [TIME_WIDTH-1:0] now_reg;
    logic                  pir_reg;
    logic                  out_vld_reg, out_vld_next;
    logic                  accept;
    logic                  advance;

    pohtrk_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cfg        (cfg),
        .preconf_wr (preconf_wr)
    );

    pohtrk_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .preconf_wr (preconf_wr),
        .step       (advance),
        .now        (now_reg),
        .pir_level  (pir_reg),
        .result     (result)
    );

    // Handshake: move the held item on whenever the result slot frees up
    assign advance      = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall     = in_vld_reg && !advance;
    assign accept       = in_valid && !in_stall;
    assign in_vld_next  = accept || (in_vld_reg && !advance);
    assign out_vld_next = advance || (out_vld_reg && out_stall);

    // Hold valid bits of both stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Capture the incoming item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            now_reg <= TIME_WIDTH'(now_ms);
            pir_reg <= pir_level;
        end
    end

    // Capture the result of the item being processed
    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= result;
    end

    assign out_valid         = out_vld_reg;
    assign occupied          = res_reg.occupied;
    assign occupancy_changed = res_reg.occupancy_changed;
    assign motion_now        = res_reg.motion_now;
    assign sensor_confirmed  = res_reg.sensor_confirmed;
    assign confirm_event     = res_reg.confirm_event;
    assign report_due        = res_reg.report_due;
    assign rescan_due        = res_reg.rescan_due;

    // Occupancy requires a confirmed sensor
    a_occ_confirmed: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && res_reg.occupied |-> res_reg.sensor_confirmed)
        else $error("occupied without confirmed sensor");

    // Fresh motion always lies within the hold window
    a_motion_occ: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && res_reg.motion_now |-> res_reg.occupied)
        else $error("motion without occupancy");

    // A confirm event leaves the sensor confirmed
    a_confirm_evt: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && res_reg.confirm_event |-> res_reg.sensor_confirmed)
        else $error("confirm event without confirmation");

    // A held item that cannot move stays held
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && !advance |=> in_vld_reg)
        else $error("input item lost while blocked");

endmodule

`default_nettype wire

// ===== rtl/pohtrk_cfg.sv =====
// Configuration register file of the PIR occupancy hold tracker.
// Depends on pohtrk_pkg for widths, indexes and reset values.
`default_nettype none

module pohtrk_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_wr_en,
    input  wire logic [pohtrk_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [pohtrk_pkg::CFG_W-1:0]     cfg_data,
    output pohtrk_pkg::cfg_t                      cfg,
    output pohtrk_pkg::preconf_wr_t               preconf_wr
);
    import pohtrk_pkg::*;

    cfg_t cfg_reg;

    // Write the addressed register; unknown indexes fall through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_ms    <= HOLD_RESET;
            cfg_reg.report_ivl <= REPORT_RESET;
            cfg_reg.rescan_ivl <= RESCAN_RESET;
            cfg_reg.run_len    <= RUN_LEN_RESET;
            cfg_reg.preconf    <= PRECONF_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_HOLD:    cfg_reg.hold_ms    <= cfg_data[HOLD_W-1:0];
                REG_REPORT:  cfg_reg.report_ivl <= cfg_data[IVL_W-1:0];
                REG_RESCAN:  cfg_reg.rescan_ivl <= cfg_data[IVL_W-1:0];
                REG_RUN_LEN: cfg_reg.run_len    <= cfg_data[RUN_W-1:0];
                REG_PRECONF: cfg_reg.preconf    <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    assign cfg = cfg_reg;

    // Let the tracker pick up a preconfirm write before the first poll
    assign preconf_wr.load  = cfg_wr_en && (cfg_index == REG_PRECONF);
    assign preconf_wr.value = cfg_data[0];

endmodule

`default_nettype wire

// ===== rtl/pohtrk_core.sv =====
// Tracker state and per-poll update logic: confirmation run, motion
// hold timer and wrap-safe report/rescan deadlines. Depends on pohtrk_pkg.
`default_nettype none

module pohtrk_core #(
    parameter int TIME_WIDTH = 32
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire pohtrk_pkg::cfg_t        cfg,
    input  wire pohtrk_pkg::preconf_wr_t preconf_wr,
    input  wire logic                    step,
    input  wire logic [TIME_WIDTH-1:0]   now,
    input  wire logic                    pir_level,
    output pohtrk_pkg::result_t          result
);
    import pohtrk_pkg::*;

    // Compare width that holds both a time and the hold register
    localparam int CMP_W = (TIME_WIDTH > HOLD_W) ? TIME_WIDTH : HOLD_W;

    logic                  confirmed_reg, confirmed_next;
    logic [RUN_W-1:0]      run_reg, run_next;
    logic [TIME_WIDTH-1:0] last_motion_reg, last_motion_next;
    logic                  seen_reg, seen_next;
    logic                  occ_prev_reg;
    logic [TIME_WIDTH-1:0] report_reg, report_next;
    logic [TIME_WIDTH-1:0] rescan_reg, rescan_next;
    logic                  started_reg;

    logic [TIME_WIDTH-1:0] report_dl;
    logic [TIME_WIDTH-1:0] rescan_dl;
    logic [TIME_WIDTH-1:0] report_diff;
    logic [TIME_WIDTH-1:0] rescan_diff;
    logic [TIME_WIDTH-1:0] elapsed;
    logic [RUN_W-1:0]      run_upd;
    logic                  motion;
    logic                  occ;
    logic                  rep_due;
    logic                  res_due;

    // Seed deadlines on the first poll
    assign report_dl = started_reg ? report_reg : now;
    assign rescan_dl = started_reg ? rescan_reg
                                   : now + TIME_WIDTH'(cfg.rescan_ivl);

    // Count consecutive high polls, saturating
    always_comb
    begin
        if (pir_level)
            run_upd = (run_reg == RUN_MAX) ? run_reg : run_reg + 1'b1;
        else
            run_upd = '0;
    end

    assign run_next       = confirmed_reg ? run_reg : run_upd;
    assign confirmed_next = confirmed_reg || (run_upd >= cfg.run_len);

    // Record motion time once the sensor is confirmed
    assign motion           = confirmed_next && pir_level;
    assign last_motion_next = motion ? now : last_motion_reg;
    assign seen_next        = seen_reg || motion;

    // Hold occupancy while the elapsed time stays within the hold window
    assign elapsed = now - last_motion_next;
    assign occ     = confirmed_next && seen_next &&
                     (CMP_W'(elapsed) <= CMP_W'(cfg.hold_ms));

    // Wrap-safe deadline compares: due when now - deadline is non-negative
    assign report_diff = now - report_dl;
    assign rescan_diff = now - rescan_dl;
    assign rep_due     = !report_diff[TIME_WIDTH-1];
    assign res_due     = !rescan_diff[TIME_WIDTH-1];
    assign report_next = rep_due ? now + TIME_WIDTH'(cfg.report_ivl) : report_dl;
    assign rescan_next = res_due ? now + TIME_WIDTH'(cfg.rescan_ivl) : rescan_dl;

    assign result.occupied          = occ;
    assign result.occupancy_changed = occ ^ occ_prev_reg;
    assign result.motion_now        = motion;
    assign result.sensor_confirmed  = confirmed_next;
    assign result.confirm_event     = confirmed_next && !confirmed_reg;
    assign result.report_due        = rep_due;
    assign result.rescan_due        = res_due;

    // Advance tracker state once per processed poll; a preconfirm write before the first poll sets the confirmed state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            confirmed_reg   <= PRECONF_RESET;
            run_reg         <= '0;
            last_motion_reg <= '0;
            seen_reg        <= 1'b0;
            occ_prev_reg    <= 1'b0;
            report_reg      <= '0;
            rescan_reg      <= '0;
            started_reg     <= 1'b0;
        end
        else if (step)
        begin
            confirmed_reg   <= confirmed_next;
            run_reg         <= run_next;
            last_motion_reg <= last_motion_next;
            seen_reg        <= seen_next;
            occ_prev_reg    <= occ;
            report_reg      <= report_next;
            rescan_reg      <= rescan_next;
            started_reg     <= 1'b1;
        end
        else if (preconf_wr.load && !started_reg)
        begin
            confirmed_reg <= preconf_wr.value;
        end
    end

endmodule

`default_nettype wire
